@@ design/assert_macros.svh @@
// assertion macros used by the converter unit
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ANY(lbl, clk, prop, msg)
`endif
`endif

@@ design/i2rd_pkg.sv @@
// widths, limits and the ascii digit mapping for the radix digit converter
// no dependencies
package i2rd_pkg;

  localparam int VALUE_WIDTH = 31;
  localparam int DIGIT_DEPTH = 32;
  localparam int RADIX_WIDTH = 5;
  localparam int DIGIT_WIDTH = 4;
  localparam int CHAR_WIDTH  = 7;

  localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = RADIX_WIDTH'(2);
  localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = RADIX_WIDTH'(16);

  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_WIDTH-1:0] CHAR_A    = 7'h41;
  localparam logic [DIGIT_WIDTH-1:0] DEC_TEN  = DIGIT_WIDTH'(10);

  function automatic logic [CHAR_WIDTH-1:0] to_ascii(input logic [DIGIT_WIDTH-1:0] d);
    logic [CHAR_WIDTH-1:0] c;
    if (d < DEC_TEN) begin
      c = CHAR_ZERO + CHAR_WIDTH'(d);
    end else begin
      c = CHAR_A + CHAR_WIDTH'(d - DEC_TEN);
    end
    return c;
  endfunction

endpackage

@@ design/i2rd_in_if.sv @@
// input channel: value and radix with valid/ready
// depends on i2rd_pkg
interface i2rd_in_if import i2rd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic [RADIX_WIDTH-1:0] radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

@@ design/i2rd_out_if.sv @@
// result channel: one ascii digit per word with a last mark
// depends on i2rd_pkg
interface i2rd_out_if import i2rd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CHAR_WIDTH-1:0] digit_char;
  logic                  last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

@@ design/integer_to_radix_digits_unit.sv @@
// integer to radix digits: bit-serial division, digit store, reverse read-out
// depends on i2rd_pkg, i2rd_in_if, i2rd_out_if and assert_macros.svh
//
//   channel  | dir | word
//   in_ch    | in  | value, radix
//   out_ch   | out | digit_char, last_digit (msd first, last on lsd)
//
// the restoring divider retires one quotient bit a cycle; each digit is then read
// from the store (S_READ) and sent (S_SEND), where a stalled sink holds the send.
// synchronous active-low reset returns to idle; digit store is not cleared.
// a stalled sink holds the current digit; no new word is taken until the last one leaves.
`include "assert_macros.svh"
module integer_to_radix_digits_unit import i2rd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  i2rd_in_if.sink    in_ch,
  i2rd_out_if.source out_ch
);

  localparam int IDX_W = $clog2(DIGIT_DEPTH);
  localparam int CNT_W = $clog2(DIGIT_DEPTH + 1);
  localparam int BIT_W = $clog2(VALUE_WIDTH);

  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(VALUE_WIDTH - 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGIT_DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_SEND = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] quo_r, quo_nxt;
  logic [DIGIT_WIDTH-1:0] rem_r, rem_nxt;
  logic [RADIX_WIDTH-1:0] radix_r, radix_nxt;
  logic [BIT_W-1:0]       bit_cnt_r, bit_cnt_nxt;
  logic                   qnz_r, qnz_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [DIGIT_WIDTH-1:0] rd_data_r;

  logic [DIGIT_WIDTH-1:0] digit_store [DIGIT_DEPTH];

  logic [DIGIT_WIDTH:0]   trial;
  logic                   take;
  logic [DIGIT_WIDTH-1:0] rem_sub;
  logic                   mem_we;
  logic [RADIX_WIDTH-1:0] radix_in;

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = (state_r == S_SEND);
  assign out_ch.digit_char = to_ascii(rd_data_r);
  assign out_ch.last_digit = (idx_r == '0);

  // one restoring division step
  assign trial   = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign take    = (RADIX_WIDTH'(trial) >= radix_r);
  assign rem_sub = take ? DIGIT_WIDTH'(trial - (DIGIT_WIDTH+1)'(radix_r))
                        : trial[DIGIT_WIDTH-1:0];

  always_comb begin
    if (in_ch.radix < RADIX_MIN) begin
      radix_in = RADIX_MIN;
    end else if (in_ch.radix > RADIX_MAX) begin
      radix_in = RADIX_MAX;
    end else begin
      radix_in = in_ch.radix;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    radix_nxt   = radix_r;
    bit_cnt_nxt = bit_cnt_r;
    qnz_nxt     = qnz_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    mem_we      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          quo_nxt     = in_ch.value;
          radix_nxt   = radix_in;
          rem_nxt     = '0;
          bit_cnt_nxt = '0;
          qnz_nxt     = 1'b0;
          cnt_nxt     = '0;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        quo_nxt     = {quo_r[VALUE_WIDTH-2:0], take};
        rem_nxt     = rem_sub;
        qnz_nxt     = qnz_r | take;
        bit_cnt_nxt = bit_cnt_r + BIT_W'(1);
        if (bit_cnt_r == BIT_LAST) begin
          // digit done: store remainder, restart on the quotient
          mem_we      = 1'b1;
          cnt_nxt     = cnt_r + CNT_W'(1);
          rem_nxt     = '0;
          qnz_nxt     = 1'b0;
          bit_cnt_nxt = '0;
          if (!(qnz_r | take) || (cnt_r == CNT_LAST)) begin
            idx_nxt   = cnt_r[IDX_W-1:0];
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (out_ch.ready) begin
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r - IDX_W'(1);
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      bit_cnt_r <= '0;
      qnz_r     <= 1'b0;
      cnt_r     <= '0;
      idx_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      qnz_r     <= qnz_nxt;
      cnt_r     <= cnt_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    radix_r <= radix_nxt;
  end

  // digit store, lsd at entry zero
  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_store[cnt_r[IDX_W-1:0]] <= rem_sub;
    end
    rd_data_r <= digit_store[idx_r];
  end

  `ASSERT_RST(a_rem_below_radix, clk, rst_n,
    (state_r == S_DIV) |-> ({1'b0, rem_r} < radix_r), "remainder not below radix")
  `ASSERT_RST(a_radix_range, clk, rst_n,
    (state_r != S_IDLE) |-> ((radix_r >= RADIX_MIN) && (radix_r <= RADIX_MAX)),
    "radix out of range")
  `ASSERT_RST(a_cnt_bound, clk, rst_n,
    (cnt_r <= CNT_W'(DIGIT_DEPTH)), "digit count beyond store depth")
  `ASSERT_RST(a_last_ends, clk, rst_n,
    (out_ch.valid && out_ch.ready && out_ch.last_digit) |=> (state_r == S_IDLE),
    "no return to idle after last digit")
  `ASSERT_RST(a_read_idx, clk, rst_n,
    (state_r == S_SEND) |-> ({1'b0, idx_r} < cnt_r), "read index beyond stored digits")

endmodule
